>>> rtl/abms_pkg.sv
// Package for the burst memory slave: sizes, codes and beat payload types.
// No dependencies; used by the channel interfaces, the top level, the checker and the testbench.
`timescale 1ns / 1ps

package abms_pkg;

	localparam int WORD_BYTES = 8;
	localparam int MEM_WORDS  = 8192;
	localparam int MAX_BURST  = 16;
	localparam int ID_BITS    = 8;

	localparam int DATA_W    = 8 * WORD_BYTES;
	localparam int LANE_W    = $clog2(WORD_BYTES);
	localparam int ADDR_W    = $clog2(MEM_WORDS);
	localparam int BEATS_W   = 5;
	localparam int CUR_W     = 33;
	localparam logic [CUR_W-1:0] MEM_BYTES = CUR_W'(MEM_WORDS * WORD_BYTES);
	localparam logic [7:0] ID_MASK = (ID_BITS >= 8) ? 8'hff : 8'((1 << ID_BITS) - 1);

	localparam logic [1:0] MODE_READ  = 2'd0;
	localparam logic [1:0] MODE_WADDR = 2'd1;
	localparam logic [1:0] MODE_WDATA = 2'd2;

	localparam logic KIND_RDATA = 1'b0;
	localparam logic KIND_WRESP = 1'b1;

	localparam logic [1:0] RESP_OK    = 2'd0;
	localparam logic [1:0] RESP_RANGE = 2'd1;
	localparam logic [1:0] RESP_LAST  = 2'd2;

	typedef struct packed {
		logic [1:0]  mode;
		logic [31:0] addr;
		logic [7:0]  txn_id;
		logic [3:0]  burst_len;
		logic [1:0]  size_log2;
		logic [63:0] wdata;
		logic [7:0]  strobe_req;
		logic        beat_last;
	} in_item_t;

	typedef struct packed {
		logic        kind;
		logic [7:0]  resp_id;
		logic [63:0] rdata;
		logic        last;
		logic [1:0]  status;
	} out_item_t;

endpackage

>>> rtl/abms_in_if.sv
// Request channel: valid/ready handshake with an in_item_t payload.
// Depends on abms_pkg.
`timescale 1ns / 1ps

interface abms_in_if;
	logic               valid;
	logic               ready;
	abms_pkg::in_item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

>>> rtl/abms_out_if.sv
// Response channel: valid/ready handshake with an out_item_t payload.
// Depends on abms_pkg.
`timescale 1ns / 1ps

interface abms_out_if;
	logic                valid;
	logic                ready;
	abms_pkg::out_item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

>>> rtl/abms_ram.sv
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
`timescale 1ns / 1ps

module abms_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

>>> rtl/axi_burst_memory_slave.sv
// Burst memory slave: read bursts, write address and write data beats on one
// request channel, read data and write responses on one response channel.
// Depends on abms_pkg, abms_in_if, abms_out_if and abms_ram.
//
// Usage:
//   req carries one beat per handshake: a read request (mode 0), a write
//   address (mode 1) or a write data beat (mode 2). rsp returns read data
//   beats and write responses, last marking the end of each beat's run.
//   A read request is accepted, then each beat takes one memory read and one
//   output step through the single read port (S_RD_ISSUE, then S_RD_DATA);
//   a write address is taken in the idle state. A write data beat is
//   accepted, read, then merged and written back to the word; the final
//   beat of a burst adds a response step.
//   req.ready is high only while the sequencer is idle.
//   After reset the block sweeps the memory to zero, one word a cycle,
//   with req.ready low; the first beat is taken after that.
//   The result sits in an output register; while rsp stalls the sequencer
//   waits with the next result, but while idle it still takes new requests.
`timescale 1ns / 1ps

module axi_burst_memory_slave (
	input logic         clk,
	input logic         arst_n,
	abms_in_if.sink     req,
	abms_out_if.source  rsp
);
	import abms_pkg::*;

	localparam logic [2:0] S_CLEAR    = 3'd0;
	localparam logic [2:0] S_IDLE     = 3'd1;
	localparam logic [2:0] S_RD_ISSUE = 3'd2;
	localparam logic [2:0] S_RD_DATA  = 3'd3;
	localparam logic [2:0] S_WR_READ  = 3'd4;
	localparam logic [2:0] S_WR_MERGE = 3'd5;
	localparam logic [2:0] S_WR_RESP  = 3'd6;

	logic [2:0]         state_q;
	logic [ADDR_W-1:0]  clr_idx_q;
	logic [CUR_W-1:0]   rd_cur_q;
	logic [BEATS_W-1:0] rd_left_q;
	logic [7:0]         rd_id_q;
	logic               oor_q;
	logic [31:0]        wr_cur_q;
	logic [7:0]         wr_id_q;
	logic [BEATS_W-1:0] beats_left_q;
	logic [1:0]         szl_q;
	logic               open_q;
	logic [1:0]         err_q;
	logic [63:0]        wdata_q;
	logic [7:0]         strb_q;
	logic               blast_q;
	logic               out_valid_q;
	out_item_t          out_q;

	logic               rd_side;
	logic [3:0]         beat_bytes;
	logic [CUR_W-1:0]   add_a;
	logic [CUR_W-1:0]   add_step;
	logic [CUR_W-1:0]   add_sum;
	logic               oor_now;
	logic [ADDR_W-1:0]  word_idx;
	logic [15:0]        lane_mask;
	logic [7:0]         byte_en;
	logic [DATA_W-1:0]  merged;
	logic               final_beat;
	logic [1:0]         err_next;
	logic [BEATS_W-1:0] req_beats;
	logic               out_free;

	logic               ram_we;
	logic [ADDR_W-1:0]  ram_waddr;
	logic [DATA_W-1:0]  ram_wdata;
	logic               ram_re;
	logic [DATA_W-1:0]  ram_rdata;

	abms_ram #(
		.WIDTH (DATA_W),
		.DEPTH (MEM_WORDS)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (word_idx),
		.rdata (ram_rdata)
	);

	assign req.ready = (state_q == S_IDLE);
	assign rsp.valid = out_valid_q;
	assign rsp.data  = out_q;
	assign out_free  = !out_valid_q || rsp.ready;

	// shared cursor unit: one adder and one range compare
	assign rd_side    = (state_q == S_RD_ISSUE) || (state_q == S_RD_DATA);
	assign beat_bytes = 4'd1 << szl_q;
	assign add_a      = rd_side ? rd_cur_q : {1'b0, wr_cur_q};
	assign add_step   = rd_side ? CUR_W'(WORD_BYTES) : CUR_W'(beat_bytes);
	assign add_sum    = add_a + add_step;
	assign oor_now    = (add_a >= MEM_BYTES);
	assign word_idx   = add_a[LANE_W +: ADDR_W];

	assign lane_mask  = ((16'd1 << beat_bytes) - 16'd1) << wr_cur_q[LANE_W-1:0];
	assign byte_en    = strb_q & lane_mask[7:0];
	assign final_beat = (beats_left_q <= BEATS_W'(1));

	always_comb begin
		if (({1'b0, req.data.burst_len} + 5'd1) > BEATS_W'(MAX_BURST)) begin
			req_beats = BEATS_W'(MAX_BURST);
		end else begin
			req_beats = {1'b0, req.data.burst_len} + 5'd1;
		end
	end

	always_comb begin
		err_next = err_q;
		if (oor_q && err_next == RESP_OK) begin
			err_next = RESP_RANGE;
		end
		if (blast_q != final_beat && err_next == RESP_OK) begin
			err_next = RESP_LAST;
		end
	end

	always_comb begin
		for (int i = 0; i < WORD_BYTES; i++) begin
			merged[8*i +: 8] = byte_en[i] ? wdata_q[8*i +: 8] : ram_rdata[8*i +: 8];
		end
	end

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = word_idx;
		ram_wdata = merged;
		ram_re    = 1'b0;
		unique case (state_q) inside
			S_CLEAR: begin
				ram_we    = 1'b1;
				ram_waddr = clr_idx_q;
				ram_wdata = '0;
			end
			S_RD_ISSUE, S_WR_READ: begin
				ram_re = 1'b1;
			end
			S_WR_MERGE: begin
				ram_we = !oor_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_CLEAR;
			clr_idx_q    <= '0;
			rd_cur_q     <= '0;
			rd_left_q    <= '0;
			rd_id_q      <= '0;
			oor_q        <= 1'b0;
			wr_cur_q     <= '0;
			wr_id_q      <= '0;
			beats_left_q <= '0;
			szl_q        <= '0;
			open_q       <= 1'b0;
			err_q        <= RESP_OK;
			wdata_q      <= '0;
			strb_q       <= '0;
			blast_q      <= 1'b0;
			out_valid_q  <= 1'b0;
			out_q        <= '0;
		end else begin
			if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_CLEAR: begin
					clr_idx_q <= clr_idx_q + 1'b1;
					if (clr_idx_q == ADDR_W'(MEM_WORDS - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (req.valid) begin
						case (req.data.mode)
							MODE_READ: begin
								rd_cur_q  <= {1'b0, req.data.addr[31:LANE_W], {LANE_W{1'b0}}};
								rd_left_q <= req_beats - 1'b1;
								rd_id_q   <= req.data.txn_id & ID_MASK;
								state_q   <= S_RD_ISSUE;
							end
							MODE_WADDR: begin
								if (!open_q) begin
									wr_cur_q     <= req.data.addr;
									wr_id_q      <= req.data.txn_id & ID_MASK;
									beats_left_q <= req_beats;
									szl_q        <= req.data.size_log2;
									open_q       <= 1'b1;
									err_q        <= RESP_OK;
								end
							end
							MODE_WDATA: begin
								if (open_q) begin
									wdata_q <= req.data.wdata;
									strb_q  <= req.data.strobe_req;
									blast_q <= req.data.beat_last;
									state_q <= S_WR_READ;
								end
							end
							default: begin
							end
						endcase
					end
				end
				S_RD_ISSUE: begin
					oor_q   <= oor_now;
					state_q <= S_RD_DATA;
				end
				S_RD_DATA: begin
					if (out_free) begin
						out_valid_q   <= 1'b1;
						out_q.kind    <= KIND_RDATA;
						out_q.resp_id <= rd_id_q;
						out_q.rdata   <= oor_q ? 64'd0 : 64'(ram_rdata);
						out_q.last    <= (rd_left_q == '0);
						out_q.status  <= oor_q ? RESP_RANGE : RESP_OK;
						if (rd_left_q == '0) begin
							state_q <= S_IDLE;
						end else begin
							rd_cur_q  <= add_sum;
							rd_left_q <= rd_left_q - 1'b1;
							state_q   <= S_RD_ISSUE;
						end
					end
				end
				S_WR_READ: begin
					oor_q   <= oor_now;
					state_q <= S_WR_MERGE;
				end
				S_WR_MERGE: begin
					wr_cur_q <= add_sum[31:0];
					err_q    <= err_next;
					if (final_beat) begin
						open_q       <= 1'b0;
						beats_left_q <= '0;
						state_q      <= S_WR_RESP;
					end else begin
						beats_left_q <= beats_left_q - 1'b1;
						state_q      <= S_IDLE;
					end
				end
				S_WR_RESP: begin
					if (out_free) begin
						out_valid_q   <= 1'b1;
						out_q.kind    <= KIND_WRESP;
						out_q.resp_id <= wr_id_q;
						out_q.rdata   <= 64'd0;
						out_q.last    <= 1'b1;
						out_q.status  <= err_q;
						state_q       <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

`ifndef SYNTHESIS
	a_open_count: assert property (@(posedge clk) disable iff (!arst_n)
		open_q == (beats_left_q != '0))
		else $error("burst open flag and beat count disagree");

	a_wr_only_merge: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we && state_q != S_CLEAR |-> state_q == S_WR_MERGE && !oor_q)
		else $error("memory write outside an in-range merge");

	a_resp_closed: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_WR_RESP |-> !open_q)
		else $error("write response while burst still open");

	a_waddr_opens: assert property (@(posedge clk) disable iff (!arst_n)
		req.valid && req.ready && req.data.mode == MODE_WADDR |=> open_q)
		else $error("write address left no open burst");
`endif

endmodule

>>> sim/abms_checker.sv
// Response checker for the burst memory slave: watches both channels, keeps a
// memory image and the open write burst, and compares every response beat.
// Depends on abms_pkg, abms_in_if and abms_out_if.
`timescale 1ns / 1ps

module abms_checker (
	input  logic clk,
	input  logic arst_n,
	abms_in_if   req,
	abms_out_if  rsp,
	output int   mismatches,
	output int   expected_left,
	output int   results_seen
);
	import abms_pkg::*;

	logic [DATA_W-1:0] mem_image [MEM_WORDS];
	logic [31:0]       wr_cursor;
	logic [7:0]        wr_id;
	logic [4:0]        wr_beats_left;
	logic [3:0]        wr_beat_bytes;
	logic              wr_open;
	logic [1:0]        wr_status;

	out_item_t responses_due [$];
	int        fail_tally;
	int        seen_tally;
	int        due_count;

	assign mismatches    = fail_tally;
	assign expected_left = due_count;
	assign results_seen  = seen_tally;

	task automatic predict_responses(input in_item_t it);
		logic [63:0] base;
		logic [63:0] byte_addr;
		logic [31:0] lane_mask;
		logic [7:0]  lane_en;
		logic [63:0] word;
		logic        final_beat;
		int          beats;
		out_item_t   beat;
		beats = int'(it.burst_len) + 1;
		if (beats > MAX_BURST)
			beats = MAX_BURST;
		case (it.mode)
			MODE_READ: begin
				base = ({32'd0, it.addr} / WORD_BYTES) * WORD_BYTES;
				for (int i = 0; i < beats; i++) begin
					byte_addr    = base + 64'(i) * WORD_BYTES;
					beat.kind    = KIND_RDATA;
					beat.resp_id = it.txn_id & ID_MASK;
					beat.last    = (i == beats - 1);
					if (byte_addr >= 64'(MEM_BYTES)) begin
						beat.rdata  = '0;
						beat.status = RESP_RANGE;
					end else begin
						beat.rdata  = mem_image[byte_addr / WORD_BYTES];
						beat.status = RESP_OK;
					end
					responses_due.push_back(beat);
				end
			end
			MODE_WADDR: begin
				if (!wr_open) begin
					wr_cursor     = it.addr;
					wr_id         = it.txn_id & ID_MASK;
					wr_beats_left = 5'(beats);
					wr_beat_bytes = 4'd1 << it.size_log2;
					wr_open       = 1'b1;
					wr_status     = RESP_OK;
				end
			end
			MODE_WDATA: begin
				if (wr_open) begin
					if ({1'b0, wr_cursor} >= MEM_BYTES) begin
						if (wr_status == RESP_OK)
							wr_status = RESP_RANGE;
					end else begin
						lane_mask = ((32'd1 << wr_beat_bytes) - 32'd1) << (wr_cursor % WORD_BYTES);
						lane_en   = it.strobe_req & lane_mask[7:0];
						word      = mem_image[wr_cursor / WORD_BYTES];
						for (int b = 0; b < WORD_BYTES; b++)
							if (lane_en[b])
								word[8*b +: 8] = it.wdata[8*b +: 8];
						mem_image[wr_cursor / WORD_BYTES] = word;
					end
					wr_cursor  = wr_cursor + 32'(wr_beat_bytes);
					final_beat = (wr_beats_left <= 5'd1);
					if (it.beat_last != final_beat && wr_status == RESP_OK)
						wr_status = RESP_LAST;
					if (wr_beats_left > 0)
						wr_beats_left--;
					if (final_beat) begin
						wr_open       = 1'b0;
						wr_beats_left = '0;
						beat.kind     = KIND_WRESP;
						beat.resp_id  = wr_id;
						beat.rdata    = '0;
						beat.last     = 1'b1;
						beat.status   = wr_status;
						responses_due.push_back(beat);
					end
				end
			end
			default: ;
		endcase
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		out_item_t due;
		if (!arst_n) begin
			foreach (mem_image[i])
				mem_image[i] = '0;
			wr_cursor     = '0;
			wr_id         = '0;
			wr_beats_left = '0;
			wr_beat_bytes = '0;
			wr_open       = 1'b0;
			wr_status     = RESP_OK;
			responses_due.delete();
			fail_tally    = 0;
			seen_tally    = 0;
			due_count     = 0;
		end else begin
			if (rsp.valid && rsp.ready) begin
				seen_tally++;
				if (responses_due.size() == 0) begin
					fail_tally++;
					if (fail_tally <= 10)
						$display("%0t: response beat with none expected: kind %0d id %02h status %0d",
							$realtime, rsp.data.kind, rsp.data.resp_id, rsp.data.status);
				end else begin
					due = responses_due.pop_front();
					if (rsp.data.kind !== due.kind || rsp.data.resp_id !== due.resp_id ||
						rsp.data.rdata !== due.rdata || rsp.data.last !== due.last ||
						rsp.data.status !== due.status) begin
						fail_tally++;
						if (fail_tally <= 10) begin
							$display("%0t: response %0d mismatch", $realtime, seen_tally);
							$display("  exp kind %0d id %02h data %016h last %0d status %0d",
								due.kind, due.resp_id, due.rdata, due.last, due.status);
							$display("  got kind %0d id %02h data %016h last %0d status %0d",
								rsp.data.kind, rsp.data.resp_id, rsp.data.rdata,
								rsp.data.last, rsp.data.status);
						end
					end
				end
			end
			if (req.valid && req.ready)
				predict_responses(req.data);
			due_count = responses_due.size();
		end
	end

endmodule

>>> sim/axi_burst_memory_slave_tb.sv
// Testbench top for the burst memory slave: clock, reset, request stimulus,
// random response stalls and the verdict. Depends on abms_pkg, both channel
// interfaces, the RTL top and abms_checker.
`timescale 1ns / 1ps

module axi_burst_memory_slave_tb;
	import abms_pkg::*;

	localparam logic [1:0] MODE_SPARE = 2'd3;

	localparam int FLAW_NONE  = 0;
	localparam int FLAW_LAST  = 1;
	localparam int FLAW_SHORT = 2;
	localparam int FLAW_EXTRA = 3;

	logic clk;
	logic arst_n;
	bit   steady;
	int   beats_sent;
	int   mismatches;
	int   expected_left;
	int   results_seen;

	abms_in_if  req ();
	abms_out_if rsp ();

	axi_burst_memory_slave i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	abms_checker i_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.req           (req),
		.rsp           (rsp),
		.mismatches    (mismatches),
		.expected_left (expected_left),
		.results_seen  (results_seen)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#200000;
		$display("Verification failed");
		$finish;
	end

	always @(posedge clk) begin
		rsp.ready <= arst_n && (steady || ($urandom_range(0, 99) >= 17));
	end

	function automatic in_item_t random_item();
		in_item_t it;
		it.mode       = 2'($urandom_range(0, 3));
		it.addr       = $urandom();
		it.txn_id     = 8'($urandom());
		it.burst_len  = 4'($urandom());
		it.size_log2  = 2'($urandom());
		it.wdata      = {$urandom(), $urandom()};
		it.strobe_req = 8'($urandom());
		it.beat_last  = 1'($urandom());
		return it;
	endfunction

	function automatic logic [31:0] pick_addr();
		int r;
		r = $urandom_range(0, 9);
		if (r < 6)
			return 32'($urandom_range(0, 511));
		else if (r < 8)
			return 32'($urandom_range(32'h0000_ff80, 32'h0001_0040));
		return $urandom();
	endfunction

	function automatic logic [3:0] pick_len();
		if ($urandom_range(0, 3) == 0)
			return 4'($urandom_range(0, 15));
		return 4'($urandom_range(0, 3));
	endfunction

	// called at a rising edge, returns at the edge where the beat was taken
	task automatic push_req(input in_item_t it);
		bit took;
		while (!steady && $urandom_range(0, 99) < 17) begin
			req.valid <= 1'b0;
			@(posedge clk);
		end
		req.valid <= 1'b1;
		req.data  <= it;
		do begin
			@(negedge clk);
			took = req.ready;
			@(posedge clk);
		end while (!took);
		beats_sent++;
	endtask

	task automatic drain();
		req.valid <= 1'b0;
		do @(negedge clk); while (expected_left != 0);
		@(posedge clk);
	endtask

	task automatic send_read(input logic [31:0] addr, input logic [3:0] len,
		input logic [7:0] id);
		in_item_t it;
		it           = random_item();
		it.mode      = MODE_READ;
		it.addr      = addr;
		it.burst_len = len;
		it.txn_id    = id;
		push_req(it);
	endtask

	task automatic send_waddr(input logic [31:0] addr, input logic [3:0] len,
		input logic [1:0] size, input logic [7:0] id);
		in_item_t it;
		it           = random_item();
		it.mode      = MODE_WADDR;
		it.addr      = addr;
		it.burst_len = len;
		it.size_log2 = size;
		it.txn_id    = id;
		push_req(it);
	endtask

	task automatic send_wbeat(input logic [63:0] wdata, input logic [7:0] strb,
		input logic last);
		in_item_t it;
		it            = random_item();
		it.mode       = MODE_WDATA;
		it.wdata      = wdata;
		it.strobe_req = strb;
		it.beat_last  = last;
		push_req(it);
	endtask

	task automatic write_burst(input logic [31:0] addr, input logic [3:0] len,
		input logic [1:0] size, input int flaw, output int sent);
		int beats;
		int slip;
		beats = int'(len) + 1;
		slip  = $urandom_range(0, len);
		if (flaw == FLAW_SHORT)
			beats--;
		if (flaw == FLAW_EXTRA)
			beats++;
		send_waddr(addr, len, size, 8'($urandom()));
		for (int k = 0; k < beats; k++)
			send_wbeat({$urandom(), $urandom()}, 8'($urandom()),
				(k == int'(len)) ^ (flaw == FLAW_LAST && k == slip));
		sent = beats + 1;
	endtask

	initial begin : stimulus
		int       counted;
		int       pick;
		int       sent;
		bit       paused;
		in_item_t it;
		arst_n    <= 1'b0;
		req.valid <= 1'b0;
		req.data  <= '0;
		steady     = 1'b0;
		beats_sent = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_read(32'h0000_0000, 4'd0, 8'h00);
		send_waddr(32'h0000_0000, 4'd1, 2'd3, 8'hff);
		send_wbeat(64'hffff_ffff_ffff_ffff, 8'hff, 1'b0);
		send_wbeat(64'h0123_4567_89ab_cdef, 8'h5a, 1'b1);
		send_read(32'h0000_0007, 4'd1, 8'h81);
		// full-word beat at lane 3: upper lanes fall off the word
		send_waddr(32'h0000_0003, 4'd0, 2'd3, 8'h12);
		send_wbeat(64'haaaa_aaaa_aaaa_aaaa, 8'hff, 1'b1);
		// second address while a burst is open is ignored
		send_waddr(32'h0000_0100, 4'd1, 2'd2, 8'h34);
		send_waddr(32'h0000_0200, 4'd3, 2'd0, 8'h56);
		send_wbeat(64'h1111_2222_3333_4444, 8'h0f, 1'b0);
		send_wbeat(64'h5555_6666_7777_8888, 8'hf0, 1'b1);
		// stray beat, no burst open
		send_wbeat(64'hdead_beef_dead_beef, 8'hff, 1'b1);
		// last flag early, then missing
		send_waddr(32'h0000_0040, 4'd2, 2'd0, 8'h78);
		send_wbeat(64'h0000_0000_0000_00c1, 8'h01, 1'b1);
		send_wbeat(64'h0000_0000_0000_c200, 8'h02, 1'b0);
		send_wbeat(64'h0000_0000_00c3_0000, 8'h04, 1'b0);
		// out of range before a bad last flag: range error wins
		send_waddr(32'h0001_0000, 4'd1, 2'd3, 8'h9a);
		send_wbeat(64'h0f0f_0f0f_0f0f_0f0f, 8'hff, 1'b1);
		send_wbeat(64'hf0f0_f0f0_f0f0_f0f0, 8'hff, 1'b1);
		// cursor wraps from the top of the address space to zero
		send_waddr(32'hffff_fffc, 4'd1, 2'd2, 8'hbc);
		send_wbeat(64'h0000_0000_0000_0000, 8'hff, 1'b0);
		send_wbeat(64'hcafe_f00d_cafe_f00d, 8'hff, 1'b1);
		send_read(32'h0000_fff8, 4'd2, 8'hde);
		send_read(32'hffff_ffff, 4'd15, 8'hff);
		it      = random_item();
		it.mode = MODE_SPARE;
		push_req(it);

		drain();

		counted = 0;
		paused  = 1'b0;
		while (counted < 85) begin
			steady = (counted >= 30 && counted < 60);
			if (counted >= 45 && !paused) begin
				drain();
				paused = 1'b1;
			end
			pick = $urandom_range(0, 99);
			if (pick < 35) begin
				send_read(pick_addr(), pick_len(), 8'($urandom()));
				counted++;
			end else if (pick < 92) begin
				write_burst(pick_addr(), pick_len(), 2'($urandom()),
					(pick < 80) ? FLAW_NONE : $urandom_range(FLAW_LAST, FLAW_EXTRA), sent);
				counted += sent;
			end else begin
				push_req(random_item());
				counted++;
			end
		end
		steady = 1'b0;
		req.valid <= 1'b0;

		do @(negedge clk); while (expected_left != 0);
		repeat (20) @(posedge clk);

		$display("Run covered %0d request beats: corner cases, random reads, write bursts",
			beats_sent);
		$display("and checked %0d response beats against the predicted memory image.",
			results_seen);
		if (mismatches == 0 && expected_left == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

>>> files.f
rtl/abms_pkg.sv
rtl/abms_in_if.sv
rtl/abms_out_if.sv
rtl/abms_ram.sv
rtl/axi_burst_memory_slave.sv
sim/abms_checker.sv
sim/axi_burst_memory_slave_tb.sv
